[rtl/rsq_pkg.sv]
// Shared types and constants of the rotated sprite quad expander.
// Holds the particle side-band record, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
package rsq_pkg;

  localparam int ZW = 36;
  localparam int XW = 32;
  localparam int OW = 34;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] TWO_PI_Z  = 36'sd26986075409;
  localparam logic signed [ZW-1:0] PI_Z      = TWO_PI_Z / 2;
  localparam logic signed [ZW-1:0] HALF_PI_Z = TWO_PI_Z / 4;

  localparam logic signed [20:0] RECIP_TWO_PI = 21'sd667544;
  localparam int RECIP_SHIFT = 38;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30     = 32'sd1073741824;

  localparam logic signed [OW:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [OW:0] SAT_MIN = -35'sd2147483648;

  localparam logic [1:0] CORNER_LL = 2'd0;
  localparam logic [1:0] CORNER_LR = 2'd1;
  localparam logic [1:0] CORNER_UR = 2'd2;
  localparam logic [1:0] CORNER_UL = 2'd3;

  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        h;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
    logic [31:0]        color;
    logic               last;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic signed [OW-1:0] pa;
    logic signed [OW-1:0] na;
    logic signed [OW-1:0] pb;
    logic signed [OW-1:0] nb;
  } offs_t;

endpackage

[rtl/rsq_angle_reduce.sv]
// Angle reduction pipeline: five stages that take the Q16.16 angle to a Q32 angle
// folded into [-pi/2, pi/2] with a negate flag. Depends on rsq_pkg.
module rsq_angle_reduce import rsq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [31:0]   in_angle,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output logic                 out_neg,
  output side_t                out_side
);

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  side_t                side1_r, side2_r, side3_r, side4_r, side5_r;
  logic signed [52:0]   prod1_r, prod1_nxt;
  logic signed [31:0]   ang1_r;
  logic signed [14:0]   quo;
  logic signed [50:0]   qc2_r, qc2_nxt;
  logic signed [47:0]   a2_r;
  logic signed [50:0]   diff;
  logic signed [ZW-1:0] rr3_r, rr3_nxt;
  logic signed [ZW-1:0] z4_r, z4_nxt;
  logic signed [ZW-1:0] z5_r, z5_nxt;
  logic                 neg5_r, neg5_nxt;

  always_comb begin
    prod1_nxt = in_angle * RECIP_TWO_PI;
    quo       = prod1_r[52:RECIP_SHIFT];
    qc2_nxt   = quo * TWO_PI_Z;
    diff      = a2_r - qc2_r;
    if (diff < 0) begin
      rr3_nxt = ZW'(diff + TWO_PI_Z);
    end else if (diff >= TWO_PI_Z) begin
      rr3_nxt = ZW'(diff - TWO_PI_Z);
    end else begin
      rr3_nxt = ZW'(diff);
    end
    z4_nxt   = (rr3_r > PI_Z) ? rr3_r - TWO_PI_Z : rr3_r;
    z5_nxt   = z4_r;
    neg5_nxt = 1'b0;
    if (z4_r > HALF_PI_Z) begin
      z5_nxt   = z4_r - PI_Z;
      neg5_nxt = 1'b1;
    end else if (z4_r < -HALF_PI_Z) begin
      z5_nxt   = z4_r + PI_Z;
      neg5_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= prod1_nxt;
      ang1_r  <= in_angle;
      side1_r <= in_side;
      qc2_r   <= qc2_nxt;
      a2_r    <= {ang1_r, 16'h0000};
      side2_r <= side1_r;
      rr3_r   <= rr3_nxt;
      side3_r <= side2_r;
      z4_r    <= z4_nxt;
      side4_r <= side3_r;
      z5_r    <= z5_nxt;
      neg5_r  <= neg5_nxt;
      side5_r <= side4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_z     = z5_r;
  assign out_neg   = neg5_r;
  assign out_side  = side5_r;

endmodule

[rtl/rsq_cordic_stage.sv]
// One registered rotation-mode CORDIC iteration with a fixed shift of STEP.
// Depends on rsq_pkg for widths, the arctangent table and the side-band record.
module rsq_cordic_stage import rsq_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic                 in_neg,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic                 out_neg,
  output side_t                out_side
);

  localparam logic signed [ZW-1:0] DZ = $signed({4'b0000, ATAN_Q30[STEP], 2'b00});

  logic                 v_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 neg_r;
  side_t                side_r;

  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    if (!in_z[ZW-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - DZ;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      neg_r  <= in_neg;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_neg   = neg_r;
  assign out_side  = side_r;

endmodule

[rtl/rsq_rotate.sv]
// Corner offset pipeline: four stages that apply the fold sign, multiply sine and cosine
// by the half size, form the sum and difference and round the four offsets. Depends on rsq_pkg.
module rsq_rotate import rsq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_cos,
  input  logic signed [XW-1:0] in_sin,
  input  logic                 in_neg,
  input  side_t                in_side,
  output logic                 out_valid,
  output offs_t                out_offs,
  output side_t                out_side
);

  logic                 v1_r, v2_r, v3_r, v4_r;
  side_t                side1_r, side2_r, side3_r, side4_r;
  logic signed [XW-1:0] cs1_r, sn1_r, cs1_nxt, sn1_nxt;
  logic signed [31:0]   h_s;
  logic signed [63:0]   p1_r, p2_r;
  logic signed [64:0]   a3_r, b3_r;
  offs_t                offs4_r, offs4_nxt;

  function automatic logic signed [OW-1:0] round_q30(input logic signed [64:0] v);
    logic signed [65:0] t;
    t = 66'(v) + 66'sd536870912;
    return t[OW+29:30];
  endfunction

  always_comb begin
    if (in_side.zero) begin
      cs1_nxt = ONE_Q30;
      sn1_nxt = '0;
    end else if (in_neg) begin
      cs1_nxt = -in_cos;
      sn1_nxt = -in_sin;
    end else begin
      cs1_nxt = in_cos;
      sn1_nxt = in_sin;
    end
    h_s          = $signed({1'b0, side1_r.h});
    offs4_nxt.pa = round_q30(a3_r);
    offs4_nxt.na = round_q30(-a3_r);
    offs4_nxt.pb = round_q30(b3_r);
    offs4_nxt.nb = round_q30(-b3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs1_r   <= cs1_nxt;
      sn1_r   <= sn1_nxt;
      side1_r <= in_side;
      p1_r    <= cs1_r * h_s;
      p2_r    <= sn1_r * h_s;
      side2_r <= side1_r;
      a3_r    <= 65'(p1_r) + 65'(p2_r);
      b3_r    <= 65'(p1_r) - 65'(p2_r);
      side3_r <= side2_r;
      offs4_r <= offs4_nxt;
      side4_r <= side3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_offs  = offs4_r;
  assign out_side  = side4_r;

endmodule

[rtl/rsq_vertex_out.sv]
// Vertex serialiser: holds one particle and sends its four corners through a registered
// output stage, one beat per ready cycle, with saturated positions. Depends on rsq_pkg.
module rsq_vertex_out import rsq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  offs_t        in_offs,
  input  side_t        in_side,
  output logic         take,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  logic                rec_v_r;
  logic [1:0]          cnt_r;
  offs_t               rec_offs_r;
  side_t               rec_side_r;
  logic                load_out;
  logic signed [OW-1:0] offx, offy;
  logic signed [OW:0]  sumx, sumy;
  logic [31:0]         vx_nxt, vy_nxt;
  logic [15:0]         u_nxt, v_nxt;
  logic                out_v_r;
  logic [127:0]        data_r;
  logic [2:0]          user_r;
  logic                last_r;

  function automatic logic [31:0] sat32(input logic signed [OW:0] s);
    if (s > SAT_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (s < SAT_MIN) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  assign load_out = rec_v_r && (!out_v_r || out_tready);
  assign take     = !rec_v_r || (load_out && (cnt_r == CORNER_UL));

  always_comb begin
    case (cnt_r)
      CORNER_LL: begin
        offx  = rec_offs_r.nb;
        offy  = rec_offs_r.na;
        u_nxt = rec_side_r.tl;
        v_nxt = rec_side_r.tt;
      end
      CORNER_LR: begin
        offx  = rec_offs_r.pa;
        offy  = rec_offs_r.nb;
        u_nxt = rec_side_r.tr;
        v_nxt = rec_side_r.tt;
      end
      CORNER_UR: begin
        offx  = rec_offs_r.pb;
        offy  = rec_offs_r.pa;
        u_nxt = rec_side_r.tr;
        v_nxt = rec_side_r.tb;
      end
      default: begin
        offx  = rec_offs_r.na;
        offy  = rec_offs_r.pb;
        u_nxt = rec_side_r.tl;
        v_nxt = rec_side_r.tb;
      end
    endcase
    sumx   = (OW+1)'(rec_side_r.cx) + (OW+1)'(offx);
    sumy   = (OW+1)'(rec_side_r.cy) + (OW+1)'(offy);
    vx_nxt = sat32(sumx);
    vy_nxt = sat32(sumy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_v_r <= 1'b0;
      cnt_r   <= CORNER_LL;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        rec_v_r <= in_valid;
        cnt_r   <= CORNER_LL;
      end else if (load_out) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= rec_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_offs_r <= in_offs;
      rec_side_r <= in_side;
    end
    if (load_out) begin
      data_r <= {rec_side_r.color, v_nxt, u_nxt, vy_nxt, vx_nxt};
      user_r <= {cnt_r == CORNER_UL, cnt_r};
      last_r <= (cnt_r == CORNER_UL) && rec_side_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

[rtl/rotated_sprite_quad_expander.sv]
// Top level of the rotated sprite quad expander: angle reduction, CORDIC chain, corner
// offsets and vertex serialiser. Depends on rsq_pkg and the four rsq_ submodules.
//
// Each particle beat on the input gives four vertex beats on the output, in the order
// lower-left, lower-right, upper-right, upper-left. A particle passes through
// 5 + CORDIC_STEPS (at most 24) + 4 pipeline stages, a holding register and an output
// register before its first vertex appears. The vertex serialiser sends one vertex per
// cycle while the output is ready and takes the next particle as it loads the upper-left
// corner of the one it holds; the pipeline takes a new particle in any cycle in which its
// tail can move on, and stalls as a whole while the output is held. A zero angle yields
// the unrotated square.
module rotated_sprite_quad_expander import rsq_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, half_size, angle, tex_left, tex_top, tex_right, tex_bottom,
  // color_rgba, one zero pad bit
  input  logic [223:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_x, vertex_y, tex_u, tex_v, vertex_color
  output logic [127:0] out_tdata,
  // corner, last_of_particle
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  logic                 adv;
  logic                 take;
  side_t                in_side;
  logic signed [31:0]   in_angle;

  logic                 cv   [NSTEPS+1];
  logic signed [XW-1:0] cx_s [NSTEPS+1];
  logic signed [XW-1:0] cy_s [NSTEPS+1];
  logic signed [ZW-1:0] cz_s [NSTEPS+1];
  logic                 cn_s [NSTEPS+1];
  side_t                cs_s [NSTEPS+1];

  logic                 rot_valid;
  offs_t                rot_offs;
  side_t                rot_side;

  assign in_angle      = $signed(in_tdata[126:95]);
  assign in_side.cx    = $signed(in_tdata[31:0]);
  assign in_side.cy    = $signed(in_tdata[63:32]);
  assign in_side.h     = in_tdata[94:64];
  assign in_side.tl    = in_tdata[142:127];
  assign in_side.tt    = in_tdata[158:143];
  assign in_side.tr    = in_tdata[174:159];
  assign in_side.tb    = in_tdata[190:175];
  assign in_side.color = in_tdata[222:191];
  assign in_side.last  = in_tlast;
  assign in_side.zero  = (in_angle == 32'sd0);

  assign adv       = !rot_valid || take;
  assign in_tready = adv;

  rsq_angle_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_angle  (in_angle),
    .in_side   (in_side),
    .out_valid (cv[0]),
    .out_z     (cz_s[0]),
    .out_neg   (cn_s[0]),
    .out_side  (cs_s[0])
  );

  assign cx_s[0] = CORDIC_GAIN;
  assign cy_s[0] = '0;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_cordic
    rsq_cordic_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (cv[i]),
      .in_x      (cx_s[i]),
      .in_y      (cy_s[i]),
      .in_z      (cz_s[i]),
      .in_neg    (cn_s[i]),
      .in_side   (cs_s[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx_s[i+1]),
      .out_y     (cy_s[i+1]),
      .out_z     (cz_s[i+1]),
      .out_neg   (cn_s[i+1]),
      .out_side  (cs_s[i+1])
    );
  end

  rsq_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cv[NSTEPS]),
    .in_cos    (cx_s[NSTEPS]),
    .in_sin    (cy_s[NSTEPS]),
    .in_neg    (cn_s[NSTEPS]),
    .in_side   (cs_s[NSTEPS]),
    .out_valid (rot_valid),
    .out_offs  (rot_offs),
    .out_side  (rot_side)
  );

  rsq_vertex_out u_vout (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rot_valid),
    .in_offs    (rot_offs),
    .in_side    (rot_side),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (rot_valid && !adv) |=> rot_valid)
    else $error("pipeline tail lost a particle while stalled");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (out_tuser[1:0] != CORNER_UL))
      |=> (out_tvalid && (out_tuser[1:0] == $past(out_tuser[1:0]) + 2'd1)))
    else $error("corner sequence broken within a particle");

  a_last_on_ul: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tlast || out_tuser[2])) |-> (out_tuser[1:0] == CORNER_UL))
    else $error("end marker on a corner other than upper-left");

  a_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !rot_valid) |=> (!u_vout.rec_v_r || $past(!take)))
    else $error("serialiser filled without a particle");

endmodule

[bench/rotated_sprite_quad_expander_test.sv]
// Self-checking bench for rotated_sprite_quad_expander: directed and random particles with
// vertices predicted by a local fixed-point CORDIC model and checked beat by beat.
// Depends on rsq_pkg and the RTL of the expander; needs no files or arguments.
module rotated_sprite_quad_expander_test;
  import rsq_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 11;
  localparam longint TWO_PI_Q32 = 64'sd26986075409;
  localparam longint PI_Q32 = TWO_PI_Q32 / 2;
  localparam longint HALF_PI_Q32 = TWO_PI_Q32 / 4;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd102944;
  localparam logic signed [31:0] ANG_PI = 32'sd205887;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        half;
    logic signed [31:0] ang;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tr;
    logic [15:0]        tb;
    logic [31:0]        colour;
    logic               last;
  } particle_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] u;
    logic [15:0] v;
    logic [31:0] colour;
    logic [1:0]  corner;
    logic        last_of_particle;
    logic        last_of_frame;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [223:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [127:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  vertex_t expected_vertices[$];
  int failures = 0;
  int burst_left = 0;

  rotated_sprite_quad_expander #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void cordic_sin_cos(input logic signed [31:0] ang, output longint sn,
                                         output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = (longint'(ang) * 65536) % TWO_PI_Q32;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (z < 0) z += TWO_PI_Q32;
    if (z > PI_Q32) z -= TWO_PI_Q32;
    if (z > HALF_PI_Q32) begin
      z -= PI_Q32;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q32) begin
      z += PI_Q32;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= 4 * longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += 4 * longint'(ATAN_Q30[i]);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // Appends the four corners of one particle, in emission order, to the expected queue.
  function automatic void expand_particle(input particle_t p);
    longint sn, cs, ox, oy, rx, ry, vx, vy, h;
    vertex_t vtx;
    logic [1:0] corners [4] = '{CORNER_LL, CORNER_LR, CORNER_UR, CORNER_UL};
    sn = 0;
    cs = 0;
    h = longint'(p.half);
    if (p.ang != 0) cordic_sin_cos(p.ang, sn, cs);
    foreach (corners[k]) begin
      ox = (corners[k] == CORNER_LL || corners[k] == CORNER_UL) ? -h : h;
      oy = (corners[k] == CORNER_LL || corners[k] == CORNER_LR) ? -h : h;
      if (p.ang == 0) begin
        vx = longint'(p.cx) + ox;
        vy = longint'(p.cy) + oy;
      end else begin
        rx = cs * ox - sn * oy;
        ry = sn * ox + cs * oy;
        vx = longint'(p.cx) + ((rx + (longint'(1) << 29)) >>> 30);
        vy = longint'(p.cy) + ((ry + (longint'(1) << 29)) >>> 30);
      end
      vtx.x = clamp_q16(vx);
      vtx.y = clamp_q16(vy);
      vtx.u = (corners[k] == CORNER_LL || corners[k] == CORNER_UL) ? p.tl : p.tr;
      vtx.v = (corners[k] == CORNER_LL || corners[k] == CORNER_LR) ? p.tt : p.tb;
      vtx.colour = p.colour;
      vtx.corner = corners[k];
      vtx.last_of_particle = (corners[k] == CORNER_UL);
      vtx.last_of_frame = (corners[k] == CORNER_UL) && p.last;
      expected_vertices = {expected_vertices, vtx};
    end
  endfunction

  function automatic particle_t make_particle(input logic signed [31:0] cx,
                                              input logic signed [31:0] cy,
                                              input logic [30:0] half,
                                              input logic signed [31:0] ang);
    particle_t p;
    p.cx = cx;
    p.cy = cy;
    p.half = half;
    p.ang = ang;
    p.tl = 16'($urandom);
    p.tt = 16'($urandom);
    p.tr = 16'($urandom);
    p.tb = 16'($urandom);
    p.colour = $urandom;
    p.last = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  task automatic send_particle(input particle_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, p.colour, p.tb, p.tr, p.tt, p.tl, p.ang, p.half, p.cy, p.cx};
    in_tlast <= p.last;
    do @(posedge clk); while (!in_tready);
    expand_particle(p);
  endtask

  task automatic test_unrotated_square();
    send_particle(make_particle(32'sd0, 32'sd0, 31'd0, 32'sd0));
    send_particle(make_particle(32'sd0, 32'sd0, 31'd65536, 32'sd0));
    send_particle(make_particle(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 32'sd0));
    send_particle(make_particle(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 32'sd0));
    send_particle(make_particle(32'sh7FFFFFFF, 32'sh80000000, 31'd1, 32'sd0));
  endtask

  task automatic test_angle_folding();
    logic signed [31:0] angles [14] = '{
      32'sd1, -32'sd1, ANG_HALF_PI - 1, ANG_HALF_PI, ANG_HALF_PI + 1, -ANG_HALF_PI,
      ANG_PI, -ANG_PI, 32'sd308831, 32'sd411775, -32'sd411775, 32'sd51472,
      32'sh7FFFFFFF, 32'sh80000000
    };
    foreach (angles[i]) send_particle(make_particle(32'sd0, 32'sd0, 31'd1048576, angles[i]));
  endtask

  task automatic test_rotated_saturation();
    send_particle(make_particle(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 32'sd51472));
    send_particle(make_particle(32'sd0, 32'sd0, 31'h7FFFFFFF, -32'sd51472));
    send_particle(make_particle(32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, ANG_PI));
  endtask

  task automatic test_texture_and_colour();
    particle_t p;
    p = make_particle(32'sd65536, -32'sd65536, 31'd32768, 32'sd0);
    {p.tl, p.tt, p.tr, p.tb, p.colour, p.last} = {64'h0, 32'h0, 1'b1};
    send_particle(p);
    {p.tl, p.tt, p.tr, p.tb, p.colour, p.last} = {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFFFFFF, 1'b0};
    send_particle(p);
    {p.tl, p.tt, p.tr, p.tb, p.colour, p.last} = {64'h0000_FFFF_FFFF_0000, 32'h12345678, 1'b1};
    send_particle(p);
  endtask

  task automatic test_random_particles(input int count);
    particle_t p;
    logic signed [31:0] ang, cx, cy;
    logic [30:0] half;
    repeat (count) begin
      case ($urandom_range(0, 7)) inside
        0: ang = 0;
        [1:3]: ang = $urandom_range(0, 1) ? $urandom_range(1, 1000000)
                                          : -$urandom_range(1, 1000000);
        default: ang = $urandom;
      endcase
      half = $urandom_range(0, 1) ? 31'($urandom_range(0, 1 << 22)) : 31'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        cx = $urandom;
        cy = $urandom;
      end else begin
        cx = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        cy = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      end
      p = make_particle(cx, cy, half, ang);
      send_particle(p);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex beat with no particle outstanding: %h", out_tdata);
        failures++;
      end else begin
        want = expected_vertices.pop_front();
        check_field("vertex_x", want.x, out_tdata[31:0]);
        check_field("vertex_y", want.y, out_tdata[63:32]);
        check_field("tex_u", 32'(want.u), 32'(out_tdata[79:64]));
        check_field("tex_v", 32'(want.v), 32'(out_tdata[95:80]));
        check_field("vertex_color", want.colour, out_tdata[127:96]);
        check_field("corner", 32'(want.corner), 32'(out_tuser[1:0]));
        check_field("last_of_particle", 32'(want.last_of_particle), 32'(out_tuser[2]));
        check_field("last_of_frame", 32'(want.last_of_frame), 32'(out_tlast));
      end
    end
  end

  // The receiver changes between always ready, random, mostly stalled and periodic stalls.
  initial begin
    int phase_left = 0;
    int ready_mode = 0;
    int tick = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(8, 80);
      end
      phase_left--;
      tick++;
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (tick % 7 != 3);
      endcase
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_unrotated_square();
    test_angle_folding();
    test_rotated_saturation();
    test_texture_and_colour();
    test_random_particles(400);
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
